// ----- rtl/core/tfg_pkg.sv -----
// tfg_pkg: constants, op codes and saturation helpers for the tangent frame generator
// used by tangent_frame_generator; no dependencies
package tfg_pkg;

    localparam int VERTEX_SLOTS = 1024;
    localparam int ADDR_W       = $clog2(VERTEX_SLOTS);
    localparam int IDX_W        = 10;
    localparam int CRD_W        = 32;
    localparam int SUM_W        = 48;
    localparam int LIM_W        = 16;
    localparam int OUT_W        = 16;

    // vertex word: pos x, y, z, tex u, v, normal x, y, z
    localparam int VTX_FIELDS   = 8;
    localparam int VTX_W        = VTX_FIELDS * CRD_W;
    localparam int F_NORM       = 5;
    // sum word: tangent x, y, z then bitangent x, y, z
    localparam int SUMW_W       = 6 * SUM_W;

    localparam int S_TDATA_W    = 288;
    localparam int M_TDATA_W    = 64;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TRI   = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam logic [1:0] REG_DEGENERATE = 2'd0;
    localparam logic [1:0] REG_LENGTH     = 2'd1;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < 64'shFFFF_FFFF_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] mag48(input logic signed [SUM_W-1:0] x);
        return x[SUM_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic idx_ok(input logic [IDX_W-1:0] i);
        return 32'(i) < VERTEX_SLOTS;
    endfunction

endpackage

// ----- rtl/core/tangent_frame_generator.sv -----
// tangent_frame_generator: per-vertex tangent accumulation and query
// vertex memory, sum memory, one shared 32x32 multiplier, radix-2 divider, bit-pair sqrt
// depends on tfg_pkg
// one word in flight at a time; the next word is taken when the block is back in idle
// triangle: three vertex reads, 14 multiplies, six divides and three sum read-modify-writes;
//   all after the determinant is left out when skipped; divider runs one quotient bit a cycle
// query: three extra divides when the tangent is normalized, plus any wait
//   for the result register to empty
// reset: synchronous, active low; a clearing pass over all VERTEX_SLOTS slots zeroes the sum
//   memory after reset before the first word is taken; limits reset to 7
module tangent_frame_generator
    import tfg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // corner_a, corner_b, corner_c, pos_x, pos_y, pos_z, tex_u, tex_v,
    // norm_x, norm_y, norm_z, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // vertex_index, tangent_x, tangent_y, tangent_z, left_handed, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_index,
    input  logic [LIM_W-1:0]     cfg_wr_data
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_VRD, ST_DELTA, ST_MUL, ST_ACC,
        ST_DIV_LOAD, ST_DIV, ST_DIV_END, ST_SUM_RD, ST_SUM_UPD,
        ST_Q_RD, ST_Q_CAP, ST_SQRT, ST_Q_SEL, ST_OUT
    } state_t;

    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(VERTEX_SLOTS - 1);
    localparam logic [4:0]        T_DEN     = 5'd1;
    localparam logic [4:0]        T_LAST    = 5'd13;
    localparam logic [4:0]        Q_PRE     = 5'd8;
    localparam logic [4:0]        Q_CROSS   = 5'd9;
    localparam logic [4:0]        Q_LAST    = 5'd17;
    localparam logic [5:0]        DIV_LAST  = 6'd63;
    localparam logic [4:0]        SQ_LAST   = 5'd31;

    // memories
    logic [VTX_W-1:0]  vert_mem [VERTEX_SLOTS];
    logic [SUMW_W-1:0] sum_mem  [VERTEX_SLOTS];
    logic [VTX_W-1:0]  vrd_reg;
    logic [SUMW_W-1:0] srd_reg;
    logic [ADDR_W-1:0] vert_ra, sum_ra, sum_wa;
    logic              vert_we, sum_we;
    logic [SUMW_W-1:0] sum_wd;

    state_t            state_reg;
    op_t               op_reg;
    logic [ADDR_W-1:0] idx_reg [3];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [1:0]        vcnt_reg;
    logic [1:0]        corner_reg;
    logic [4:0]        step_reg;
    logic [LIM_W-1:0]  deg_limit_reg, len_limit_reg;

    logic signed [31:0] pos_reg [3][3];
    logic signed [31:0] tex_reg [3][2];
    logic signed [31:0] e1_reg [3], e2_reg [3];
    logic signed [31:0] s1_reg, s2_reg, t1_reg, t2_reg;
    logic signed [SUM_W-1:0] den_reg;
    logic signed [SUM_W-1:0] tnum_reg [3], bnum_reg [3];
    logic signed [SUM_W-1:0] tv_reg [3], bv_reg [3];

    logic signed [31:0] n_reg [3], t_reg [3], b_reg [3], g_reg [3], c_reg [3];
    logic signed [31:0] dot_reg;
    logic signed [OUT_W-1:0] o_reg [3];
    logic signed [63:0] acc_reg;

    // shared multiplier
    logic signed [31:0]      mul_a, mul_b;
    logic signed [63:0]      prod_reg;
    logic signed [SUM_W-1:0] mq;

    // divider
    logic [63:0]      dvd_reg;
    logic [SUM_W-1:0] dvs_reg, rem_reg;
    logic [5:0]       div_cnt_reg;
    logic             div_neg_reg, div_b_reg;
    logic [1:0]       div_k_reg;
    logic [SUM_W:0]   div_trial;

    // square root
    logic [63:0] sq_x_reg, sq_r_reg, sq_bit_reg;
    logic [4:0]  sq_cnt_reg;
    logic [63:0] sq_sum;

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tvalid_reg;

    logic                    s_acc;
    logic                    out_load;
    logic [4:0]              tj;
    logic [1:0]              tk;
    logic signed [SUM_W-1:0] den_new, num_sel, q_sat;
    logic [63:0]             q_tri;
    logic [OUT_W-1:0]        q_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign mq      = SUM_W'(prod_reg >>> 16);
    assign tj      = step_reg - 5'd2;
    assign tk      = tj[3:2];
    assign den_new = den_reg - mq;
    assign num_sel = div_b_reg ? bnum_reg[div_k_reg] : tnum_reg[div_k_reg];
    assign div_trial = {rem_reg, dvd_reg[63]};
    assign sq_sum  = sq_r_reg + sq_bit_reg;
    assign q_tri   = dvd_reg;
    assign q_sat   = (|q_tri[63:SUM_W-1]) ? SUM_MAX : q_tri[SUM_W-1:0];
    assign q_out   = dvd_reg[OUT_W-1:0];

    // memory ports
    always_comb begin
        vert_we = s_acc && (op_t'(s_tuser) == OP_LOAD) && idx_ok(s_tdata[9:0]);
        vert_ra = idx_reg[0];
        sum_ra  = idx_reg[0];
        if (state_reg == ST_VRD && vcnt_reg != 2'd3) begin
            vert_ra = idx_reg[vcnt_reg];
        end
        if (state_reg == ST_SUM_RD) begin
            sum_ra = idx_reg[corner_reg];
        end
        sum_we = 1'b0;
        sum_wa = clr_cnt_reg;
        sum_wd = '0;
        if (state_reg == ST_CLEAR) begin
            sum_we = 1'b1;
        end else if (state_reg == ST_SUM_UPD) begin
            sum_we = 1'b1;
            sum_wa = idx_reg[corner_reg];
            for (int k = 0; k < 3; k++) begin
                sum_wd[SUM_W*k +: SUM_W] =
                    sat_add(srd_reg[SUM_W*k +: SUM_W], tv_reg[k]);
                sum_wd[SUM_W*(k+3) +: SUM_W] =
                    sat_add(srd_reg[SUM_W*(k+3) +: SUM_W], bv_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (vert_we) begin
            vert_mem[ADDR_W'(s_tdata[9:0])] <= s_tdata[30 +: VTX_W];
        end
        vrd_reg <= vert_mem[vert_ra];
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_wa] <= sum_wd;
        end
        srd_reg <= sum_mem[sum_ra];
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (op_reg == OP_TRI) begin
            if (step_reg == 5'd0) begin
                mul_a = s1_reg; mul_b = t2_reg;
            end else if (step_reg == T_DEN) begin
                mul_a = s2_reg; mul_b = t1_reg;
            end else begin
                unique case (tj[1:0])
                    2'd0: begin mul_a = t2_reg; mul_b = e1_reg[tk]; end
                    2'd1: begin mul_a = t1_reg; mul_b = e2_reg[tk]; end
                    2'd2: begin mul_a = s1_reg; mul_b = e2_reg[tk]; end
                    2'd3: begin mul_a = s2_reg; mul_b = e1_reg[tk]; end
                endcase
            end
        end else begin
            unique case (step_reg)
                5'd0:  begin mul_a = n_reg[0]; mul_b = t_reg[0]; end
                5'd1:  begin mul_a = n_reg[1]; mul_b = t_reg[1]; end
                5'd2:  begin mul_a = n_reg[2]; mul_b = t_reg[2]; end
                5'd3:  begin mul_a = n_reg[0]; mul_b = dot_reg; end
                5'd4:  begin mul_a = n_reg[1]; mul_b = dot_reg; end
                5'd5:  begin mul_a = n_reg[2]; mul_b = dot_reg; end
                5'd6:  begin mul_a = g_reg[0]; mul_b = g_reg[0]; end
                5'd7:  begin mul_a = g_reg[1]; mul_b = g_reg[1]; end
                5'd8:  begin mul_a = g_reg[2]; mul_b = g_reg[2]; end
                5'd9:  begin mul_a = n_reg[1]; mul_b = 32'(o_reg[2]); end
                5'd10: begin mul_a = n_reg[2]; mul_b = 32'(o_reg[1]); end
                5'd11: begin mul_a = n_reg[2]; mul_b = 32'(o_reg[0]); end
                5'd12: begin mul_a = n_reg[0]; mul_b = 32'(o_reg[2]); end
                5'd13: begin mul_a = n_reg[0]; mul_b = 32'(o_reg[1]); end
                5'd14: begin mul_a = n_reg[1]; mul_b = 32'(o_reg[0]); end
                5'd15: begin mul_a = c_reg[0]; mul_b = b_reg[0]; end
                5'd16: begin mul_a = c_reg[1]; mul_b = b_reg[1]; end
                5'd17: begin mul_a = c_reg[2]; mul_b = b_reg[2]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // control and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            deg_limit_reg <= LIM_W'(7);
            len_limit_reg <= LIM_W'(7);
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_DEGENERATE) begin
                    deg_limit_reg <= cfg_wr_data;
                end else if (cfg_wr_index == REG_LENGTH) begin
                    len_limit_reg <= cfg_wr_data;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        op_reg     <= op_t'(s_tuser);
                        idx_reg[0] <= ADDR_W'(s_tdata[9:0]);
                        idx_reg[1] <= ADDR_W'(s_tdata[19:10]);
                        idx_reg[2] <= ADDR_W'(s_tdata[29:20]);
                        vcnt_reg   <= '0;
                        clr_cnt_reg <= '0;
                        unique case (op_t'(s_tuser))
                            OP_LOAD: state_reg <= ST_IDLE;
                            OP_TRI: begin
                                if (idx_ok(s_tdata[9:0]) && idx_ok(s_tdata[19:10])
                                    && idx_ok(s_tdata[29:20])) begin
                                    state_reg <= ST_VRD;
                                end
                            end
                            OP_QUERY: begin
                                if (idx_ok(s_tdata[9:0])) begin
                                    state_reg <= ST_Q_RD;
                                end
                            end
                            OP_CLEAR: state_reg <= ST_CLEAR;
                        endcase
                    end
                end
                ST_VRD: begin
                    // read data arrives in the cycle after its address
                    if (vcnt_reg != 2'd0) begin
                        for (int k = 0; k < 3; k++) begin
                            pos_reg[vcnt_reg - 2'd1][k] <= vrd_reg[CRD_W*k +: CRD_W];
                        end
                        tex_reg[vcnt_reg - 2'd1][0] <= vrd_reg[CRD_W*3 +: CRD_W];
                        tex_reg[vcnt_reg - 2'd1][1] <= vrd_reg[CRD_W*4 +: CRD_W];
                    end
                    vcnt_reg <= vcnt_reg + 1'b1;
                    if (vcnt_reg == 2'd3) begin
                        state_reg <= ST_DELTA;
                    end
                end
                ST_DELTA: begin
                    for (int k = 0; k < 3; k++) begin
                        e1_reg[k] <= sat32(64'(pos_reg[1][k]) - 64'(pos_reg[0][k]));
                        e2_reg[k] <= sat32(64'(pos_reg[2][k]) - 64'(pos_reg[0][k]));
                    end
                    s1_reg    <= sat32(64'(tex_reg[1][0]) - 64'(tex_reg[0][0]));
                    s2_reg    <= sat32(64'(tex_reg[2][0]) - 64'(tex_reg[0][0]));
                    t1_reg    <= sat32(64'(tex_reg[1][1]) - 64'(tex_reg[0][1]));
                    t2_reg    <= sat32(64'(tex_reg[2][1]) - 64'(tex_reg[0][1]));
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    step_reg <= step_reg + 1'b1;
                    if (op_reg == OP_TRI) begin
                        if (step_reg == 5'd0) begin
                            den_reg   <= mq;
                            state_reg <= ST_MUL;
                        end else if (step_reg == T_DEN) begin
                            den_reg <= den_new;
                            // zero or too small determinant skips the triangle
                            if (den_new == '0
                                || mag48(den_new) < SUM_W'(deg_limit_reg)) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                state_reg <= ST_MUL;
                            end
                        end else begin
                            unique case (tj[1:0])
                                2'd0: tnum_reg[tk] <= mq;
                                2'd1: tnum_reg[tk] <= tnum_reg[tk] - mq;
                                2'd2: bnum_reg[tk] <= mq;
                                2'd3: bnum_reg[tk] <= bnum_reg[tk] - mq;
                            endcase
                            if (step_reg == T_LAST) begin
                                div_k_reg <= '0;
                                div_b_reg <= 1'b0;
                                state_reg <= ST_DIV_LOAD;
                            end else begin
                                state_reg <= ST_MUL;
                            end
                        end
                    end else begin
                        unique case (step_reg)
                            5'd0:  acc_reg <= 64'(mq);
                            5'd1:  acc_reg <= acc_reg + 64'(mq);
                            5'd2:  dot_reg <= sat32(acc_reg + 64'(mq));
                            5'd3:  g_reg[0] <= sat32(64'(t_reg[0]) - 64'(mq));
                            5'd4:  g_reg[1] <= sat32(64'(t_reg[1]) - 64'(mq));
                            5'd5:  g_reg[2] <= sat32(64'(t_reg[2]) - 64'(mq));
                            5'd6:  acc_reg <= prod_reg;
                            5'd7:  acc_reg <= acc_reg + prod_reg;
                            5'd8: begin
                                sq_x_reg   <= acc_reg + prod_reg;
                                sq_r_reg   <= '0;
                                sq_bit_reg <= 64'h4000_0000_0000_0000;
                                sq_cnt_reg <= '0;
                            end
                            5'd9:  acc_reg <= prod_reg;
                            5'd10: c_reg[0] <= sat32((acc_reg - prod_reg) >>> 16);
                            5'd11: acc_reg <= prod_reg;
                            5'd12: c_reg[1] <= sat32((acc_reg - prod_reg) >>> 16);
                            5'd13: acc_reg <= prod_reg;
                            5'd14: c_reg[2] <= sat32((acc_reg - prod_reg) >>> 16);
                            5'd15: acc_reg <= prod_reg >>> 2;
                            5'd16: acc_reg <= acc_reg + (prod_reg >>> 2);
                            5'd17: acc_reg <= acc_reg + (prod_reg >>> 2);
                            default: acc_reg <= acc_reg;
                        endcase
                        if (step_reg == Q_PRE) begin
                            state_reg <= ST_SQRT;
                        end else if (step_reg == Q_LAST) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_DIV_LOAD: begin
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    if (op_reg == OP_TRI) begin
                        dvd_reg     <= {mag48(num_sel), 16'b0};
                        dvs_reg     <= mag48(den_reg);
                        div_neg_reg <= num_sel[SUM_W-1] ^ den_reg[SUM_W-1];
                    end else begin
                        dvd_reg     <= {18'b0, mag32(g_reg[div_k_reg]), 14'b0};
                        dvs_reg     <= SUM_W'(sq_r_reg[31:0]);
                        div_neg_reg <= g_reg[div_k_reg][31];
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // one quotient bit per cycle, shifted into the dividend
                    if (div_trial >= {1'b0, dvs_reg}) begin
                        rem_reg <= SUM_W'(div_trial - {1'b0, dvs_reg});
                        dvd_reg <= {dvd_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= div_trial[SUM_W-1:0];
                        dvd_reg <= {dvd_reg[62:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_LAST) begin
                        state_reg <= ST_DIV_END;
                    end
                end
                ST_DIV_END: begin
                    if (op_reg == OP_TRI) begin
                        if (div_b_reg) begin
                            bv_reg[div_k_reg] <= div_neg_reg ? -q_sat : q_sat;
                        end else begin
                            tv_reg[div_k_reg] <= div_neg_reg ? -q_sat : q_sat;
                        end
                        if (div_k_reg == 2'd2) begin
                            div_k_reg <= '0;
                            div_b_reg <= 1'b1;
                            if (div_b_reg) begin
                                corner_reg <= '0;
                                state_reg  <= ST_SUM_RD;
                            end else begin
                                state_reg  <= ST_DIV_LOAD;
                            end
                        end else begin
                            div_k_reg <= div_k_reg + 1'b1;
                            state_reg <= ST_DIV_LOAD;
                        end
                    end else begin
                        o_reg[div_k_reg] <= div_neg_reg ? -q_out : q_out;
                        if (div_k_reg == 2'd2) begin
                            step_reg  <= Q_CROSS;
                            state_reg <= ST_MUL;
                        end else begin
                            div_k_reg <= div_k_reg + 1'b1;
                            state_reg <= ST_DIV_LOAD;
                        end
                    end
                end
                ST_SUM_RD: begin
                    state_reg <= ST_SUM_UPD;
                end
                ST_SUM_UPD: begin
                    // write lands before the next corner's read, so repeats stack
                    corner_reg <= corner_reg + 1'b1;
                    state_reg  <= (corner_reg == 2'd2) ? ST_IDLE : ST_SUM_RD;
                end
                ST_Q_RD: begin
                    state_reg <= ST_Q_CAP;
                end
                ST_Q_CAP: begin
                    for (int k = 0; k < 3; k++) begin
                        n_reg[k] <= vrd_reg[CRD_W*(F_NORM+k) +: CRD_W];
                        t_reg[k] <= sat32(64'($signed(srd_reg[SUM_W*k +: SUM_W])));
                        b_reg[k] <= sat32(64'($signed(srd_reg[SUM_W*(k+3) +: SUM_W])));
                    end
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_SQRT: begin
                    if (sq_x_reg >= sq_sum) begin
                        sq_x_reg <= sq_x_reg - sq_sum;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == SQ_LAST) begin
                        state_reg <= ST_Q_SEL;
                    end
                end
                ST_Q_SEL: begin
                    if (sq_r_reg[31:0] > 32'(len_limit_reg)) begin
                        div_k_reg <= '0;
                        state_reg <= ST_DIV_LOAD;
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            o_reg[k] <= OUT_W'(sat32(64'(g_reg[k] >>> 2)) > 32'sd32767 ?
                                        32'sd32767 : (g_reg[k] >>> 2) < -32'sd32768 ?
                                        -32'sd32768 : (g_reg[k] >>> 2));
                        end
                        step_reg  <= Q_CROSS;
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_tdata_reg  <= {5'b0, acc_reg[63], o_reg[2], o_reg[1], o_reg[0],
                                         IDX_W'(idx_reg[0])};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    ap_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_cnt_reg == DIV_LAST) |=> (state_reg == ST_DIV_END))
        else $error("divider did not finish after its last bit");

    ap_sqrt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_SEL) |-> (sq_r_reg[63:32] == '0))
        else $error("square root result exceeds 32 bits");

    ap_unit_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_END && op_reg == OP_QUERY) |-> (dvd_reg <= 64'd16384))
        else $error("normalized tangent component above one");

    ap_clear_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && clr_cnt_reg != CLR_LAST) |=> (state_reg == ST_CLEAR))
        else $error("clearing pass ended early");

    ap_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result word raised outside the output state");

endmodule

// ----- verif/testbench.sv -----
// testbench: self-checking bench for tangent_frame_generator with a fixed-point tangent predictor
// depends on tfg_pkg and the tangent_frame_generator rtl
`timescale 1ns / 100ps

module testbench;
    import tfg_pkg::*;

    // Q16.16 helpers for the predictor
    function automatic longint fl(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint s32(longint x);
        return clip(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint absl(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint dir_div(longint num, longint den);
        longint smax;
        longint q;
        smax = 64'sh7FFF_FFFF_FFFF;
        q = (absl(num) <<< 16) / absl(den);
        if (q > smax) q = smax;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    class tangent_scoreboard;
        longint pos[VERTEX_SLOTS][3];
        longint tex[VERTEX_SLOTS][2];
        longint nrm[VERTEX_SLOTS][3];
        longint tsum[VERTEX_SLOTS][3];
        longint bsum[VERTEX_SLOTS][3];
        longint deg_lim;
        longint len_lim;
        logic [M_TDATA_W-1:0] tangents_due[$];
        int errors;

        function new();
            deg_lim = 7;
            len_lim = 7;
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            foreach (tsum[i, k]) begin
                tsum[i][k] = 0;
                bsum[i][k] = 0;
            end
        endfunction

        function void set_limit(logic [1:0] idx, logic [15:0] v);
            if (idx == REG_DEGENERATE) deg_lim = v;
            else if (idx == REG_LENGTH) len_lim = v;
        endfunction

        function void accumulate(int i0, int i1, int i2);
            longint e1[3], e2[3], tv[3], bv[3];
            longint s1, s2, t1, t2, den, smax, smin;
            int ix[3];
            smax = 64'sh7FFF_FFFF_FFFF;
            smin = -smax - 1;
            ix[0] = i0; ix[1] = i1; ix[2] = i2;
            for (int k = 0; k < 3; k++) begin
                e1[k] = s32(pos[i1][k] - pos[i0][k]);
                e2[k] = s32(pos[i2][k] - pos[i0][k]);
            end
            s1 = s32(tex[i1][0] - tex[i0][0]);
            s2 = s32(tex[i2][0] - tex[i0][0]);
            t1 = s32(tex[i1][1] - tex[i0][1]);
            t2 = s32(tex[i2][1] - tex[i0][1]);
            den = qmul(s1, t2) - qmul(s2, t1);
            if (den == 0 || absl(den) < deg_lim) return;
            for (int k = 0; k < 3; k++) begin
                tv[k] = dir_div(qmul(t2, e1[k]) - qmul(t1, e2[k]), den);
                bv[k] = dir_div(qmul(s1, e2[k]) - qmul(s2, e1[k]), den);
            end
            for (int c = 0; c < 3; c++)
                for (int k = 0; k < 3; k++) begin
                    tsum[ix[c]][k] = clip(tsum[ix[c]][k] + tv[k], smin, smax);
                    bsum[ix[c]][k] = clip(bsum[ix[c]][k] + bv[k], smin, smax);
                end
        endfunction

        function logic [M_TDATA_W-1:0] tangent_of(int i);
            longint t[3], b[3], g[3], o[3], c[3], dot, hs, len;
            longint unsigned len2;
            logic [M_TDATA_W-1:0] w;
            len2 = 0;
            for (int k = 0; k < 3; k++) begin
                t[k] = s32(tsum[i][k]);
                b[k] = s32(bsum[i][k]);
            end
            dot = s32(qmul(nrm[i][0], t[0]) + qmul(nrm[i][1], t[1]) + qmul(nrm[i][2], t[2]));
            for (int k = 0; k < 3; k++) begin
                g[k] = s32(t[k] - qmul(nrm[i][k], dot));
                len2 += longint'(g[k] * g[k]);
            end
            len = root(len2);
            for (int k = 0; k < 3; k++) begin
                if (len > len_lim) o[k] = (g[k] < 0 ? -1 : 1) * ((absl(g[k]) * 16384) / len);
                else o[k] = clip(fl(g[k], 2), -32768, 32767);
            end
            c[0] = s32(fl(nrm[i][1] * o[2] - nrm[i][2] * o[1], 16));
            c[1] = s32(fl(nrm[i][2] * o[0] - nrm[i][0] * o[2], 16));
            c[2] = s32(fl(nrm[i][0] * o[1] - nrm[i][1] * o[0], 16));
            hs = fl(c[0] * b[0], 2) + fl(c[1] * b[1], 2) + fl(c[2] * b[2], 2);
            w = '0;
            w[9:0] = i[9:0];
            w[25:10] = o[0][15:0];
            w[41:26] = o[1][15:0];
            w[57:42] = o[2][15:0];
            w[58] = hs < 0;
            return w;
        endfunction

        function void note_word(op_t op, logic [S_TDATA_W-1:0] d);
            int a, b, c;
            a = d[9:0]; b = d[19:10]; c = d[29:20];
            case (op)
                OP_LOAD: begin
                    for (int k = 0; k < 3; k++) begin
                        pos[a][k] = longint'($signed(d[30 + 32*k +: 32]));
                        nrm[a][k] = longint'($signed(d[190 + 32*k +: 32]));
                    end
                    tex[a][0] = longint'($signed(d[126 +: 32]));
                    tex[a][1] = longint'($signed(d[158 +: 32]));
                end
                OP_TRI: accumulate(a, b, c);
                OP_QUERY: tangents_due = {tangents_due, tangent_of(a)};
                default: clear_sums();
            endcase
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] exp;
            if (tangents_due.size() == 0) begin
                $error("unexpected word %h", got);
                errors++;
                return;
            end
            exp = tangents_due.pop_front();
            if (got[9:0] !== exp[9:0]) begin
                $error("vertex_index exp %0d got %0d", exp[9:0], got[9:0]); errors++;
            end
            if (got[25:10] !== exp[25:10]) begin
                $error("tangent_x exp %h got %h", exp[25:10], got[25:10]); errors++;
            end
            if (got[41:26] !== exp[41:26]) begin
                $error("tangent_y exp %h got %h", exp[41:26], got[41:26]); errors++;
            end
            if (got[57:42] !== exp[57:42]) begin
                $error("tangent_z exp %h got %h", exp[57:42], got[57:42]); errors++;
            end
            if (got[58] !== exp[58]) begin
                $error("left_handed exp %b got %b", exp[58], got[58]); errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = OP_LOAD;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_wr_index = REG_DEGENERATE;
    logic [LIM_W-1:0] cfg_wr_data = '0;

    tangent_scoreboard sb = new();
    int idle_cycles = 0;
    int loaded[$];       // slots that hold vertex data
    bit stall_mode = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    tangent_frame_generator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    // receiver: stalls come in phases, some with none at all
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // watchdog: flags a mismatch and stops once the idle count passes its limit
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(op_t op, logic [S_TDATA_W-1:0] d);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, d);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    function automatic logic [S_TDATA_W-1:0] pack(int a, int b, int c, logic [255:0] v);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[9:0] = a[9:0]; d[19:10] = b[9:0]; d[29:20] = c[9:0];
        d[285:30] = v;
        return d;
    endfunction

    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 2 * 786432)) - 786432;
        endcase
    endfunction

    task automatic load_vertex(int a);
        logic [255:0] v;
        for (int k = 0; k < 8; k++) v[32*k +: 32] = coord();
        if ($urandom_range(0, 3) != 0) begin
            for (int k = 5; k < 8; k++) v[32*k +: 32] = $signed($urandom_range(0, 131072)) - 65536;
        end
        send_word(OP_LOAD, pack(a, $urandom_range(0, 1023), $urandom_range(0, 1023), v));
        loaded = {loaded, a};
    endtask

    function automatic int pick();
        return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        while (sb.tangents_due.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] v);
        cfg_wr_en <= 1;
        cfg_wr_index <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_limit(idx, v);
        @(posedge aclk);
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20 || loaded.size() < 3) load_vertex($urandom_range(0, 1023));
        else if (r < 55) send_word(OP_TRI, pack(pick(), pick(), pick(), {8{$urandom}}));
        else if (r < 97) send_word(OP_QUERY, pack(pick(), $urandom, $urandom, {8{$urandom}}));
        else send_word(OP_CLEAR, pack($urandom, $urandom, $urandom, {8{$urandom}}));
    endtask

    initial begin
        logic [15:0] lims[4];
        lims = '{16'd0, 16'hFFFF, 16'd7, 16'd300};
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extreme indices, every op, repeated corners, spare register index
        set_reg(2'd2, 16'h1234);
        set_reg(2'd3, 16'hFFFF);
        load_vertex(0);
        load_vertex(1023);
        load_vertex(1);
        load_vertex(2);
        send_word(OP_TRI, pack(0, 1, 2, {8{32'hFFFF_FFFF}}));
        send_word(OP_TRI, pack(1023, 1023, 0, '0));
        send_word(OP_TRI, pack(0, 0, 0, '0));
        send_word(OP_QUERY, pack(0, 1023, 1023, {8{32'hFFFF_FFFF}}));
        send_word(OP_QUERY, pack(1023, 0, 0, '0));
        send_word(OP_QUERY, pack(1, 0, 0, '0));
        send_word(OP_CLEAR, pack(1023, 1023, 1023, {8{32'hFFFF_FFFF}}));
        send_word(OP_QUERY, pack(2, 0, 0, '0));
        for (int i = 3; i < 10; i++) load_vertex(i);

        for (int phase = 0; phase < 5; phase++) begin
            drain();
            if (phase < 4) begin
                set_reg(REG_DEGENERATE, lims[phase]);
                set_reg(REG_LENGTH, lims[3 - phase]);
            end else begin
                set_reg(REG_DEGENERATE, 16'($urandom));
                set_reg(REG_LENGTH, $urandom_range(0, 1) ? 16'hFFFF : 16'd0);
            end
            for (int n = 0; n < 100; n++) random_word();
        end
        drain();
        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/tfg_pkg.sv
rtl/core/tangent_frame_generator.sv
verif/testbench.sv
